@@ sv/btrq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package btrq_pkg;

    // The slot field is five bits wide, so no more than this many slots can be named.
    localparam int SLOT_REACH    = 32;
    localparam int DEF_NUM_SLOTS = 32;
    localparam int SLOT_W        = 5;
    localparam int COORD_W       = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QOVER  = 2'd2,
        MODE_QIN    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_USED  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        t_mode             mode;
        logic [SLOT_W-1:0] slot;
        logic              in_range;
        t_box              box;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/box_table_range_query.sv @@
// Insert and remove: one result each, registered in the command queue, then the output register;
// one item per clock when not stalled. Queries: the scan reads one stored box per cycle, while
// the output is not stalled, from the single read port of the box memory; results stream out.
// A two-entry command queue lets new items be taken while a scan is running.
// Synchronous active-low reset empties the table and the queue; box contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module box_table_range_query #(
    parameter int NUM_SLOTS = btrq_pkg::DEF_NUM_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [btrq_pkg::SLOT_W-1:0]  i_slot,
    input  logic signed [15:0]           i_box_min_x,
    input  logic signed [15:0]           i_box_min_y,
    input  logic signed [15:0]           i_box_min_z,
    input  logic signed [15:0]           i_box_max_x,
    input  logic signed [15:0]           i_box_max_y,
    input  logic signed [15:0]           i_box_max_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic                         o_hit,
    output logic [btrq_pkg::SLOT_W-1:0]  o_match_slot,
    output logic                         o_last
);

    btrq_pkg::t_box  in_box;
    btrq_pkg::t_cmd  cmd;
    logic            cmd_valid;
    logic            cmd_pop;

    always_comb begin
        in_box.min_x = i_box_min_x;
        in_box.min_y = i_box_min_y;
        in_box.min_z = i_box_min_z;
        in_box.max_x = i_box_max_x;
        in_box.max_y = i_box_max_y;
        in_box.max_z = i_box_max_z;
    end

    btrq_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_slot      (i_slot),
        .i_box       (in_box),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    btrq_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_hit        (o_hit),
        .o_match_slot (o_match_slot),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

@@ sv/btrq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module btrq_front #(
    parameter int NUM_SLOTS = btrq_pkg::DEF_NUM_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [btrq_pkg::SLOT_W-1:0]  i_slot,
    input  btrq_pkg::t_box               i_box,
    output logic                         o_cmd_valid,
    output btrq_pkg::t_cmd               o_cmd,
    input  logic                         i_cmd_pop
);

    localparam int EFF_SLOTS = (NUM_SLOTS < btrq_pkg::SLOT_REACH) ?
                               NUM_SLOTS : btrq_pkg::SLOT_REACH;
    localparam int DEPTH = btrq_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    btrq_pkg::t_cmd     r_queue [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    btrq_pkg::t_cmd     new_cmd;
    logic               push;
    logic               pop;
    logic               full;

    always_comb begin
        new_cmd.mode     = btrq_pkg::t_mode'(i_mode);
        new_cmd.slot     = i_slot;
        new_cmd.in_range = ({1'b0, i_slot} < (btrq_pkg::SLOT_W + 1)'(EFF_SLOTS));
        new_cmd.box      = i_box;
    end

    assign full        = (r_count == CNT_W'(DEPTH));
    assign o_stall     = full;
    assign push        = i_valid && !full;
    assign pop         = i_cmd_pop && (r_count != '0);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/btrq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module btrq_back #(
    parameter int NUM_SLOTS = btrq_pkg::DEF_NUM_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  btrq_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic                         o_hit,
    output logic [btrq_pkg::SLOT_W-1:0]  o_match_slot,
    output logic                         o_last
);

    localparam int EFF_SLOTS = (NUM_SLOTS < btrq_pkg::SLOT_REACH) ?
                               NUM_SLOTS : btrq_pkg::SLOT_REACH;
    localparam int IDX_W = $clog2(EFF_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EFF_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [EFF_SLOTS-1:0]          r_slot_valid, n_slot_valid;
    logic [IDX_W-1:0]              r_scan_idx, n_scan_idx;
    logic                          r_issue_done, n_issue_done;
    logic                          r_s1_valid, n_s1_valid;
    logic [IDX_W-1:0]              r_s1_idx, n_s1_idx;
    logic                          r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]              r_pend_idx, n_pend_idx;
    btrq_pkg::t_box                r_query, n_query;
    logic                          r_q_inside, n_q_inside;
    logic                          r_out_valid, n_out_valid;
    btrq_pkg::t_status             r_status, n_status;
    logic                          r_hit, n_hit;
    logic [btrq_pkg::SLOT_W-1:0]   r_mslot, n_mslot;
    logic                          r_last, n_last;

    btrq_pkg::t_box                box_mem [EFF_SLOTS];
    btrq_pkg::t_box                r_rd_box;
    logic                          mem_we;
    logic                          rd_en;
    logic [IDX_W-1:0]              cmd_idx;
    logic                          adv;
    logic                          ovl;
    logic                          ins;
    logic                          cmp_match;

    // The whole back end moves only when the output register is free to load.
    assign adv     = !r_out_valid || !i_stall;
    assign cmd_idx = i_cmd.slot[IDX_W-1:0];

    always_comb begin
        ovl = ($signed(r_rd_box.min_x) <= $signed(r_query.max_x)) &&
              ($signed(r_rd_box.max_x) >= $signed(r_query.min_x)) &&
              ($signed(r_rd_box.min_y) <= $signed(r_query.max_y)) &&
              ($signed(r_rd_box.max_y) >= $signed(r_query.min_y)) &&
              ($signed(r_rd_box.min_z) <= $signed(r_query.max_z)) &&
              ($signed(r_rd_box.max_z) >= $signed(r_query.min_z));
        ins = ($signed(r_rd_box.min_x) >= $signed(r_query.min_x)) &&
              ($signed(r_rd_box.max_x) <= $signed(r_query.max_x)) &&
              ($signed(r_rd_box.min_y) >= $signed(r_query.min_y)) &&
              ($signed(r_rd_box.max_y) <= $signed(r_query.max_y)) &&
              ($signed(r_rd_box.min_z) >= $signed(r_query.min_z)) &&
              ($signed(r_rd_box.max_z) <= $signed(r_query.max_z));
        cmp_match = r_s1_valid && r_slot_valid[r_s1_idx] && (r_q_inside ? ins : ovl);
    end

    always_comb begin
        n_state      = r_state;
        n_slot_valid = r_slot_valid;
        n_scan_idx   = r_scan_idx;
        n_issue_done = r_issue_done;
        n_s1_valid   = r_s1_valid;
        n_s1_idx     = r_s1_idx;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_query      = r_query;
        n_q_inside   = r_q_inside;
        n_out_valid  = r_out_valid && i_stall;
        n_status     = r_status;
        n_hit        = r_hit;
        n_mslot      = r_mslot;
        n_last       = r_last;
        o_cmd_pop    = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        if (adv) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        o_cmd_pop = 1'b1;
                        unique case (i_cmd.mode)
                            btrq_pkg::MODE_INSERT: begin
                                n_out_valid = 1'b1;
                                n_hit       = 1'b0;
                                n_mslot     = i_cmd.slot;
                                n_last      = 1'b1;
                                if (i_cmd.in_range && !r_slot_valid[cmd_idx]) begin
                                    n_slot_valid[cmd_idx] = 1'b1;
                                    mem_we                = 1'b1;
                                    n_status              = btrq_pkg::ST_OK;
                                end else begin
                                    n_status = btrq_pkg::ST_USED;
                                end
                            end
                            btrq_pkg::MODE_REMOVE: begin
                                n_out_valid = 1'b1;
                                n_hit       = 1'b0;
                                n_mslot     = i_cmd.slot;
                                n_last      = 1'b1;
                                if (i_cmd.in_range && r_slot_valid[cmd_idx]) begin
                                    n_slot_valid[cmd_idx] = 1'b0;
                                    n_status              = btrq_pkg::ST_OK;
                                end else begin
                                    n_status = btrq_pkg::ST_EMPTY;
                                end
                            end
                            btrq_pkg::MODE_QOVER, btrq_pkg::MODE_QIN: begin
                                n_query      = i_cmd.box;
                                n_q_inside   = (i_cmd.mode == btrq_pkg::MODE_QIN);
                                n_scan_idx   = '0;
                                n_issue_done = 1'b0;
                                n_s1_valid   = 1'b0;
                                n_pend_valid = 1'b0;
                                n_state      = S_SCAN;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    rd_en        = !r_issue_done;
                    n_s1_valid   = !r_issue_done;
                    n_s1_idx     = r_scan_idx;
                    n_scan_idx   = r_scan_idx + 1'b1;
                    n_issue_done = r_issue_done || (r_scan_idx == LAST_IDX);
                    // A match is held back until the next one shows up, so that
                    // the final match of the scan can carry the last flag.
                    if (cmp_match) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_status    = btrq_pkg::ST_OK;
                            n_hit       = 1'b1;
                            n_mslot     = btrq_pkg::SLOT_W'(r_pend_idx);
                            n_last      = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_s1_idx;
                    end
                    if (r_s1_valid && (r_s1_idx == LAST_IDX)) begin
                        n_state = S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    n_out_valid = 1'b1;
                    n_status    = btrq_pkg::ST_OK;
                    n_hit       = r_pend_valid;
                    n_mslot     = r_pend_valid ? btrq_pkg::SLOT_W'(r_pend_idx) : '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_issue_done <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_issue_done <= n_issue_done;
            r_s1_valid   <= n_s1_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= n_scan_idx;
        r_s1_idx   <= n_s1_idx;
        r_pend_idx <= n_pend_idx;
        r_query    <= n_query;
        r_q_inside <= n_q_inside;
        r_status   <= n_status;
        r_hit      <= n_hit;
        r_mslot    <= n_mslot;
        r_last     <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            box_mem[cmd_idx] <= i_cmd.box;
        end
        if (rd_en) begin
            r_rd_box <= box_mem[r_scan_idx];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_hit        = r_hit;
    assign o_match_slot = r_mslot;
    assign o_last       = r_last;

endmodule

`default_nettype wire

@@ tb/box_query_checker.sv @@
`timescale 1ns / 1ps

module box_query_checker #(
    parameter int NUM_SLOTS = btrq_pkg::DEF_NUM_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  logic                         i_cmd_stall,
    input  logic [1:0]                   i_mode,
    input  logic [btrq_pkg::SLOT_W-1:0]  i_slot,
    input  btrq_pkg::t_box               i_box,
    input  logic                         i_res_valid,
    input  logic                         i_res_stall,
    input  logic [1:0]                   i_status,
    input  logic                         i_hit,
    input  logic [btrq_pkg::SLOT_W-1:0]  i_match_slot,
    input  logic                         i_last,
    output int                           o_pending,
    output int                           o_errors,
    output int                           o_results
);

    import btrq_pkg::*;

    // Only the slots that a five-bit slot number can name take part.
    localparam int LIVE_SLOTS = (NUM_SLOTS < SLOT_REACH) ? NUM_SLOTS : SLOT_REACH;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        t_status           status;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_answer;

    t_answer               answers_q[$];
    logic [SLOT_REACH-1:0] occupied;
    t_box                  stored [SLOT_REACH];
    int                    errors;
    int                    results;

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("%0t: %s", $time, what);
        end else if (errors == PRINT_CAP + 1) begin
            $display("%0t: further mismatches are counted but not printed", $time);
        end
    endtask

    function automatic bit span_overlap(logic signed [COORD_W-1:0] s_lo, s_hi, q_lo, q_hi);
        return (s_lo <= q_hi) && (s_hi >= q_lo);
    endfunction

    function automatic bit span_within(logic signed [COORD_W-1:0] s_lo, s_hi, q_lo, q_hi);
        return (s_lo >= q_lo) && (s_hi <= q_hi);
    endfunction

    function automatic bit box_matches(t_mode mode, t_box s, t_box q);
        if (mode == MODE_QOVER) begin
            return span_overlap(s.min_x, s.max_x, q.min_x, q.max_x)
                && span_overlap(s.min_y, s.max_y, q.min_y, q.max_y)
                && span_overlap(s.min_z, s.max_z, q.min_z, q.max_z);
        end
        return span_within(s.min_x, s.max_x, q.min_x, q.max_x)
            && span_within(s.min_y, s.max_y, q.min_y, q.max_y)
            && span_within(s.min_z, s.max_z, q.min_z, q.max_z);
    endfunction

    // Applies one command to the shadow table and queues the answers it causes.
    task automatic apply_command(t_mode mode, logic [SLOT_W-1:0] slot, t_box box);
        t_answer ans;
        int      idx;
        int      found;
        found = 0;
        case (mode)
            MODE_INSERT: begin
                ans = '{ST_USED, 1'b0, slot, 1'b1};
                if (int'(slot) < LIVE_SLOTS && !occupied[slot]) begin
                    occupied[slot] = 1'b1;
                    stored[slot]   = box;
                    ans.status     = ST_OK;
                end
                answers_q = {answers_q, ans};
            end
            MODE_REMOVE: begin
                ans = '{ST_EMPTY, 1'b0, slot, 1'b1};
                if (int'(slot) < LIVE_SLOTS && occupied[slot]) begin
                    occupied[slot] = 1'b0;
                    ans.status     = ST_OK;
                end
                answers_q = {answers_q, ans};
            end
            default: begin
                for (idx = 0; idx < LIVE_SLOTS; idx++) begin
                    if (occupied[idx] && box_matches(mode, stored[idx], box)) begin
                        ans       = '{ST_OK, 1'b1, SLOT_W'(idx), 1'b0};
                        answers_q = {answers_q, ans};
                        found++;
                    end
                end
                if (found == 0) begin
                    ans       = '{ST_OK, 1'b0, '0, 1'b1};
                    answers_q = {answers_q, ans};
                end else begin
                    ans       = answers_q.pop_back();
                    ans.last  = 1'b1;
                    answers_q = {answers_q, ans};
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            occupied = '0;
            answers_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = '{t_status'(i_status), i_hit, i_match_slot, i_last};
                results++;
                if (answers_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result: status %0d hit %0b slot %0d last %0b",
                        got.status, got.hit, got.slot, got.last));
                end else begin
                    want = answers_q.pop_front();
                    if (got.status !== want.status || got.hit !== want.hit
                            || got.slot !== want.slot || got.last !== want.last) begin
                        report_mismatch($sformatf(
                            {"result mismatch: got status %0d hit %0b slot %0d last %0b, ",
                             "expected status %0d hit %0b slot %0d last %0b"},
                            got.status, got.hit, got.slot, got.last,
                            want.status, want.hit, want.slot, want.last));
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                apply_command(t_mode'(i_mode), i_slot, i_box);
            end
        end
        o_pending <= answers_q.size();
        o_errors  <= errors;
        o_results <= results;
    end

endmodule

@@ tb/tb_box_table_range_query.sv @@
`timescale 1ns / 1ps

module tb_box_table_range_query;

    import btrq_pkg::*;

    localparam int NUM_SLOTS    = DEF_NUM_SLOTS;
    localparam int RANDOM_ITEMS = 90;
    localparam int CALM_ITEMS   = 20;
    localparam int FILL_AT      = 50;
    localparam int TAIL_CYCLES  = NUM_SLOTS + 12;
    localparam int CYCLE_LIMIT  = 400000;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     i_stall     = 1'b0;
    logic [1:0]               i_mode      = MODE_INSERT;
    logic [SLOT_W-1:0]        i_slot      = '0;
    logic signed [15:0]       i_box_min_x = '0;
    logic signed [15:0]       i_box_min_y = '0;
    logic signed [15:0]       i_box_min_z = '0;
    logic signed [15:0]       i_box_max_x = '0;
    logic signed [15:0]       i_box_max_y = '0;
    logic signed [15:0]       i_box_max_z = '0;
    logic                     o_stall;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic                     o_hit;
    logic [SLOT_W-1:0]        o_match_slot;
    logic                     o_last;

    int                       pending;
    int                       errors;
    int                       results;
    int                       cycles = 0;
    int                       inserts = 0;
    int                       removes = 0;
    int                       queries = 0;
    bit                       calm = 1'b0;
    logic [SLOT_REACH-1:0]    filled = '0;

    always #5 i_clk = ~i_clk;

    box_table_range_query #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .o_stall,
        .i_mode,
        .i_slot,
        .i_box_min_x,
        .i_box_min_y,
        .i_box_min_z,
        .i_box_max_x,
        .i_box_max_y,
        .i_box_max_z,
        .o_valid,
        .i_stall,
        .o_status,
        .o_hit,
        .o_match_slot,
        .o_last
    );

    box_query_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_checker (
        .i_clk,
        .i_rst_n,
        .i_cmd_valid  (i_valid),
        .i_cmd_stall  (o_stall),
        .i_mode,
        .i_slot,
        .i_box        ({i_box_min_x, i_box_min_y, i_box_min_z,
                        i_box_max_x, i_box_max_y, i_box_max_z}),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_status     (o_status),
        .i_hit        (o_hit),
        .i_match_slot (o_match_slot),
        .i_last       (o_last),
        .o_pending    (pending),
        .o_errors     (errors),
        .o_results    (results)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_box_table_range_query failed");
            $finish;
        end
    end

    // Result side back-pressure: stall bursts mixed with longer free-running stretches.
    initial begin : result_stalls
        int burst;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 13);
                i_stall <= 1'b1;
                repeat (burst - 1) @(posedge i_clk);
            end else begin
                burst = $urandom_range(1, 40);
                i_stall <= 1'b0;
                repeat (burst - 1) @(posedge i_clk);
            end
        end
    end

    function automatic t_box make_box(int lx, int ly, int lz, int hx, int hy, int hz);
        t_box b;
        b.min_x = 16'(lx);
        b.min_y = 16'(ly);
        b.min_z = 16'(lz);
        b.max_x = 16'(hx);
        b.max_y = 16'(hy);
        b.max_z = 16'(hz);
        return b;
    endfunction

    // Mostly a crowded neighborhood around the origin so that boxes meet often.
    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 160)) - 80);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_upper(logic signed [15:0] lo, int reach);
        int sum;
        if ($urandom_range(0, 9) == 0) begin
            return pick_coord();
        end
        sum = int'(lo) + int'($urandom_range(0, reach));
        return (sum > 32767) ? 16'sh7fff : 16'(sum);
    endfunction

    function automatic t_box pick_box(int reach, bit point);
        t_box b;
        b.min_x = pick_coord();
        b.min_y = pick_coord();
        b.min_z = pick_coord();
        b.max_x = point ? b.min_x : pick_upper(b.min_x, reach);
        b.max_y = point ? b.min_y : pick_upper(b.min_y, reach);
        b.max_z = point ? b.min_z : pick_upper(b.min_z, reach);
        return b;
    endfunction

    // Picks a slot whose occupancy matches want_used, or any slot if none does.
    function automatic logic [SLOT_W-1:0] pick_slot(bit want_used);
        int start;
        int k;
        start = $urandom_range(0, NUM_SLOTS - 1);
        for (k = 0; k < NUM_SLOTS; k++) begin
            if (filled[(start + k) % NUM_SLOTS] == want_used) begin
                return SLOT_W'((start + k) % NUM_SLOTS);
            end
        end
        return SLOT_W'(start);
    endfunction

    // Optional sender gap, then one command held until its transfer completes.
    task automatic send_command(t_mode mode, logic [SLOT_W-1:0] slot, t_box box);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_slot      <= slot;
        i_box_min_x <= box.min_x;
        i_box_min_y <= box.min_y;
        i_box_min_z <= box.min_z;
        i_box_max_x <= box.max_x;
        i_box_max_y <= box.max_y;
        i_box_max_z <= box.max_z;
        do @(posedge i_clk); while (o_stall);
        case (mode)
            MODE_INSERT: begin
                inserts++;
                filled[slot] = 1'b1;
            end
            MODE_REMOVE: begin
                removes++;
                filled[slot] = 1'b0;
            end
            default: queries++;
        endcase
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int   n;
        int   k;
        int   pick;
        t_box full;
        full = make_box(-32768, -32768, -32768, 32767, 32767, 32767);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Queries on the empty table must report no match.
        send_command(MODE_QOVER, 5'd0, full);
        send_command(MODE_QIN, 5'd31, full);
        send_command(MODE_INSERT, 5'd0, full);
        send_command(MODE_INSERT, 5'd31, make_box(0, 0, 0, 10, 10, 10));
        send_command(MODE_INSERT, 5'd0, make_box(1, 2, 3, 4, 5, 6));
        send_command(MODE_REMOVE, 5'd5, full);
        send_command(MODE_INSERT, 5'd7, make_box(10, 10, 10, -10, -10, -10));
        send_command(MODE_INSERT, 5'd12, make_box(10, 0, 0, 20, 10, 10));
        send_command(MODE_INSERT, 5'd20, make_box(32767, -32768, 0, 32767, -32768, 0));
        // Point queries that sit exactly on shared faces and on the extreme corner.
        send_command(MODE_QOVER, 5'd3, make_box(10, 5, 5, 10, 5, 5));
        send_command(MODE_QOVER, 5'd3, make_box(32767, -32768, 0, 32767, -32768, 0));
        send_command(MODE_QIN, 5'd0, make_box(0, 0, 0, 10, 10, 10));
        send_command(MODE_QIN, 5'd0, make_box(1, 0, 0, 10, 10, 10));
        send_command(MODE_QOVER, 5'd0, make_box(11, 11, 11, 20, 20, 20));
        send_command(MODE_QOVER, 5'd0, make_box(5, 5, 5, -5, -5, -5));
        send_command(MODE_QIN, 5'd31, full);
        send_command(MODE_QOVER, 5'd31, full);
        send_command(MODE_REMOVE, 5'd0, full);
        send_command(MODE_REMOVE, 5'd31, full);
        send_command(MODE_REMOVE, 5'd0, full);
        send_command(MODE_QOVER, 5'd21,
                     make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_command(MODE_INSERT, 5'd0, make_box(16'h5555, 16'h5555, 16'h5555,
                                                 16'haaaa, 16'haaaa, 16'haaaa));
        send_command(MODE_QIN, 5'd10, make_box(16'haaaa, 16'haaaa, 16'haaaa,
                                               16'h5555, 16'h5555, 16'h5555));
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            if (n == FILL_AT) begin
                // Let the block run dry, then load every slot so a query returns all of them.
                drain_results();
                for (k = 0; k < NUM_SLOTS; k++) begin
                    if (!filled[k]) begin
                        send_command(MODE_INSERT, SLOT_W'(k), pick_box(40, 1'b0));
                    end
                end
                send_command(MODE_QOVER, 5'($urandom), full);
                send_command(MODE_QIN, 5'($urandom), full);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_command(MODE_INSERT,
                             ($urandom_range(0, 3) != 0) ? pick_slot(1'b0) : 5'($urandom),
                             pick_box(40, $urandom_range(0, 9) == 0));
            end else if (pick < 55) begin
                send_command(MODE_REMOVE,
                             ($urandom_range(0, 3) != 0) ? pick_slot(1'b1) : 5'($urandom),
                             pick_box(40, 1'b0));
            end else if (pick < 80) begin
                send_command(MODE_QOVER, 5'($urandom),
                             pick_box(120, $urandom_range(0, 9) == 0));
            end else begin
                send_command(MODE_QIN, 5'($urandom), pick_box(160, 1'b0));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts, %0d removes and %0d queries, including a full table,",
                 inserts, removes, queries);
        $display("inverted and extreme boxes; %0d results were compared.", results);
        if (errors == 0 && pending == 0) begin
            $display("tb_box_table_range_query passed");
        end else begin
            $display("tb_box_table_range_query failed");
        end
        $finish;
    end

endmodule
